### hdl/first_fit_heap_allocator_top_defines.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
// Check a property on the rising clock edge, outside reset.
`define FFHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same check, also active during reset.
`define FFHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hdl/ffha_pkg.sv
// Package: types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 6;
  localparam int MEM_AW  = $clog2(HEAP_BYTES);
  localparam int OFF_W   = MEM_AW + 1;
  localparam int SIZE_W  = 16;
  localparam int HDR_W   = SIZE_W + 1;

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_FREE    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_HEAP_USED = 2'd1;
  localparam logic [1:0] REG_MIN_CHUNK = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] req_size;
    logic [15:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic        ok;
  } rsp_t;

  typedef struct packed {
    logic              alloc;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_BOOT, ST_IDLE, ST_ARD, ST_AEV, ST_AWR,
    ST_FRD, ST_FEV, ST_FNX, ST_FNEV
  } state_t;
endpackage

### hdl/ffha_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/first_fit_heap_allocator_top.sv
// Top level: first-fit heap allocator with coalescing, headers kept in one RAM.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with result_valid, and must be taken then.
// Init and unknown requests answer in the cycle after acceptance. Allocate and
// free walk the header chain through the header RAM, in a read state and then
// an evaluate state for each header visited. A split adds a write state, a free
// with a block after it adds a read of that header and a write-back of the
// merge, and a walk that runs off the chain ends in an end check; the result
// follows in the cycle after the last of these, and busy drops in that
// result cycle. After reset the block writes the initial free header in
// its boot state before it accepts requests.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::req_t      req,
  output logic                result_valid,
  output ffha_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ffha_pkg::*;

  localparam logic [OFF_W-1:0]  HEAP_END_MAX = OFF_W'(HEAP_BYTES);

  logic [15:0] heap_base;
  logic [12:0] heap_used;
  logic [7:0]  min_chunk;

  state_t state, state_next;
  logic [OFF_W-1:0]  off, off_next, heap_end, heap_end_next;
  logic [OFF_W-1:0]  prev_off, prev_off_next, cur_off, cur_off_next;
  logic [11:0]       req_size_q, req_size_next;
  logic [15:0]       target, target_next;
  logic [SIZE_W-1:0] prev_size, prev_size_next, cur_size, cur_size_next;
  logic              prev_alloc, prev_alloc_next, has_prev, has_prev_next;
  logic              result_valid_next;
  rsp_t              rsp_next;
  logic              walk_req;

  logic              we;
  logic [MEM_AW-1:0] waddr, raddr;
  hdr_t              wdata, rdata;

  logic [OFF_W-1:0]  len_c;
  logic [16:0]       next_c, merge_c, nx_c, fin_c;
  logic [15:0]       left_c;
  logic [OFF_W-1:0]  nw_c;
  logic [15:0]       s_c;
  logic [OFF_W-1:0]  c_c;

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pready   = 1'b1;
  assign busy     = (state != ST_IDLE);
  assign walk_req = start && !busy && (req.req_type == REQ_ALLOC || req.req_type == REQ_FREE);

  always_comb begin
    unique case (paddr[3:2])
      REG_HEAP_BASE: prdata = {16'd0, heap_base};
      REG_HEAP_USED: prdata = {19'd0, heap_used};
      REG_MIN_CHUNK: prdata = {24'd0, min_chunk};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= 16'd0;
      heap_used <= 13'd4096;
      min_chunk <= 8'd4;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_HEAP_BASE: heap_base <= pwdata[15:0];
        REG_HEAP_USED: heap_used <= pwdata[12:0];
        REG_MIN_CHUNK: min_chunk <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_BOOT;
      heap_end     <= HEAP_END_MAX;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      heap_end     <= heap_end_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    off        <= off_next;
    prev_off   <= prev_off_next;
    cur_off    <= cur_off_next;
    req_size_q <= req_size_next;
    target     <= target_next;
    prev_size  <= prev_size_next;
    cur_size   <= cur_size_next;
    prev_alloc <= prev_alloc_next;
    has_prev   <= has_prev_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next        = state;
    heap_end_next     = heap_end;
    off_next          = off;
    prev_off_next     = prev_off;
    cur_off_next      = cur_off;
    req_size_next     = req_size_q;
    target_next       = target;
    prev_size_next    = prev_size;
    cur_size_next     = cur_size;
    prev_alloc_next   = prev_alloc;
    has_prev_next     = has_prev;
    result_valid_next = 1'b0;
    rsp_next          = rsp;
    we    = 1'b0;
    waddr = off[MEM_AW-1:0];
    wdata = '0;
    raddr = off[MEM_AW-1:0];
    len_c = (heap_used > 13'(HEAP_BYTES)) ? HEAP_END_MAX : OFF_W'(heap_used);
    next_c  = 17'(off) + 17'(HEADER_BYTES) + 17'(rdata.size);
    left_c  = rdata.size - 16'(req_size_q);
    nw_c    = off + OFF_W'(HEADER_BYTES) + OFF_W'(req_size_q);
    merge_c = 17'(prev_size) + 17'(HEADER_BYTES) + 17'(rdata.size);
    if (has_prev && !prev_alloc) begin
      s_c = merge_c[15:0];
      c_c = prev_off;
    end else begin
      s_c = rdata.size;
      c_c = off;
    end
    nx_c  = 17'(c_c) + 17'(HEADER_BYTES) + 17'(s_c);
    fin_c = 17'(cur_size) + 17'(HEADER_BYTES) + 17'(rdata.size);
    unique case (state)
      ST_BOOT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = '{alloc: 1'b0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          off_next      = '0;
          has_prev_next = 1'b0;
          req_size_next = req.req_size;
          target_next   = req.block_addr - 16'(HEADER_BYTES) - heap_base;
          rsp_next      = '{result_addr: 16'd0, ok: 1'b0};
          unique case (req.req_type)
            REQ_INIT: begin
              result_valid_next = 1'b1;
              if (len_c < OFF_W'(HEADER_BYTES)) begin
                heap_end_next = '0;
              end else begin
                heap_end_next = len_c;
                we            = 1'b1;
                waddr         = '0;
                wdata         = '{alloc: 1'b0, size: SIZE_W'(len_c - OFF_W'(HEADER_BYTES))};
                rsp_next.ok   = 1'b1;
              end
            end
            REQ_ALLOC: state_next = ST_ARD;
            REQ_FREE:  state_next = ST_FRD;
            default:   result_valid_next = 1'b1;
          endcase
        end
      end
      ST_ARD: begin
        if (off >= heap_end) begin
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_AEV;
        end
      end
      ST_AEV: begin
        if (!rdata.alloc && rdata.size >= 16'(req_size_q)) begin
          rsp_next.result_addr = heap_base + 16'(off) + 16'(HEADER_BYTES);
          rsp_next.ok          = 1'b1;
          we                   = 1'b1;
          if ({4'd0, left_c} > (20'(HEADER_BYTES) + 20'(min_chunk))) begin
            waddr      = nw_c[MEM_AW-1:0];
            wdata      = '{alloc: 1'b0, size: left_c - 16'(HEADER_BYTES)};
            state_next = ST_AWR;
          end else begin
            wdata             = '{alloc: 1'b1, size: rdata.size};
            result_valid_next = 1'b1;
            state_next        = ST_IDLE;
          end
        end else begin
          off_next   = next_c[OFF_W-1:0];
          state_next = ST_ARD;
        end
      end
      ST_AWR: begin
        we                = 1'b1;
        wdata             = '{alloc: 1'b1, size: 16'(req_size_q)};
        result_valid_next = 1'b1;
        state_next        = ST_IDLE;
      end
      ST_FRD: begin
        if (off >= heap_end) begin
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_FEV;
        end
      end
      ST_FEV: begin
        if (16'(off) == target) begin
          rsp_next.ok  = 1'b1;
          cur_off_next  = c_c;
          cur_size_next = s_c;
          if (nx_c < 17'(heap_end)) begin
            off_next   = nx_c[OFF_W-1:0];
            state_next = ST_FNX;
          end else begin
            we                = 1'b1;
            waddr             = c_c[MEM_AW-1:0];
            wdata             = '{alloc: 1'b0, size: s_c};
            result_valid_next = 1'b1;
            state_next        = ST_IDLE;
          end
        end else begin
          prev_off_next   = off;
          prev_size_next  = rdata.size;
          prev_alloc_next = rdata.alloc;
          has_prev_next   = 1'b1;
          off_next        = next_c[OFF_W-1:0];
          state_next      = ST_FRD;
        end
      end
      ST_FNX: begin
        state_next = ST_FNEV;
      end
      ST_FNEV: begin
        we    = 1'b1;
        waddr = cur_off[MEM_AW-1:0];
        wdata = '{alloc: 1'b0, size: rdata.alloc ? cur_size : fin_c[15:0]};
        result_valid_next = 1'b1;
        state_next        = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `FFHA_ASSERT(a_result_after_busy, result_valid |-> $past(busy || start), "result without transaction")
  `FFHA_ASSERT(a_start_busy, walk_req |=> busy, "walk did not start")
  `FFHA_ASSERT_ALWAYS(a_heap_end_range, rst || heap_end <= HEAP_END_MAX, "heap end out of range")
  `FFHA_ASSERT(a_fail_zero_addr, (result_valid && !rsp.ok) |-> (rsp.result_addr == 16'd0), "failed request with address")
endmodule
